>>> hdl/hpft_pkg.sv
// Shared types, codes and helpers for the handbox packet / focus tracker.
package hpft_pkg;

    localparam int unsigned PKT_LEN = 10;
    localparam int unsigned CRC_LEN = 9;

    localparam logic [3:0] CNT_MAX     = 4'd15;
    localparam logic [3:0] CNT_CRC_LEN = 4'd9;
    localparam logic [3:0] CNT_LAST    = 4'd9;

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_ZERO = 8'h00;
    localparam logic [7:0] CRC_ONE  = 8'h01;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INVERT_X    = 3'd0,
        CFG_INVERT_Y    = 3'd1,
        CFG_INVERT_WHL  = 3'd2,
        CFG_SOFT_LIM_EN = 3'd3,
        CFG_LOWER_LIM   = 3'd4,
        CFG_UPPER_LIM   = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        OP_BYTE  = 1'b0,
        OP_FOCUS = 1'b1
    } t_op;

    typedef enum logic {
        KIND_VERDICT = 1'b0,
        KIND_MOVE    = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_LEGACY   = 2'd0,
        ST_CRC_OK   = 2'd1,
        ST_CRC_FAIL = 2'd2
    } t_status;

    typedef struct packed {
        t_kind              kind;
        t_status            status;
        logic signed [15:0] x_delta;
        logic signed [15:0] y_delta;
        logic               button;
        logic signed [31:0] focus_target;
        logic [31:0]        legacy_total;
        logic [31:0]        ok_total;
        logic [31:0]        fail_total;
    } t_result;

    // CRC-8, poly 0x07, MSB first, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> hdl/hpft_out_skid.sv
// Two-entry output buffer: result register plus skid register.
module hpft_out_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hpft_pkg::t_result i_result,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_stall,
    output hpft_pkg::t_result o_result
);
    import hpft_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    take;

    assign take     = r_out_valid && !i_stall;
    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            // upstream is stalled while the skid entry is held
            if (take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || take) begin
                n_out       = i_result;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_result;
                n_skid_valid = 1'b1;
            end
        end else if (take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

>>> hdl/handbox_packet_focus_tracker_core.sv
// Top level: packet checker, wheel accumulator and focus target generator.
// One input transaction per cycle, sustained: each byte or focus request is
// handled in the cycle it is accepted and its result (if any) is registered
// into a two-entry output buffer, so the input stalls only once both entries
// are held by a stalled output. A 10-byte packet gives its verdict on the
// transaction that carries the last byte. No startup sweep: the block is
// ready right after reset.
module handbox_packet_focus_tracker_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_wr_en,
    input  logic [hpft_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hpft_pkg::CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_op,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_last_byte,
    input  logic                  i_homing_busy,
    input  logic signed [31:0]    i_motor_position,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_kind,
    output hpft_pkg::t_status     o_status,
    output logic signed [15:0]    o_x_delta,
    output logic signed [15:0]    o_y_delta,
    output logic                  o_button,
    output logic signed [31:0]    o_focus_target,
    output logic [31:0]           o_legacy_total,
    output logic [31:0]           o_ok_total,
    output logic [31:0]           o_fail_total
);
    import hpft_pkg::*;

    // configuration
    logic               r_invert_x, r_invert_y, r_invert_whl, r_soft_lim_en;
    logic signed [31:0] r_lower_lim, r_upper_lim;

    // tracker state
    logic [7:0]         r_store [CRC_LEN];
    logic [3:0]         r_byte_count, n_byte_count;
    logic [7:0]         r_crc, n_crc;
    logic [31:0]        r_wheel_last, n_wheel_last;
    logic               r_first_pkt, n_first_pkt;
    logic [31:0]        r_wheel_accum, n_wheel_accum;
    logic signed [31:0] r_focus_pos, n_focus_pos;
    logic               r_pos_synced, n_pos_synced;
    logic [31:0]        r_legacy_cnt, n_legacy_cnt;
    logic [31:0]        r_ok_cnt, n_ok_cnt;
    logic [31:0]        r_fail_cnt, n_fail_cnt;

    logic               in_accept;
    logic               store_we;
    logic               res_valid;
    t_result            res;
    t_result            out_res;
    logic               skid_full;

    // datapath temporaries
    logic [7:0]         crc_calc;
    logic               pkt_pass;
    logic [31:0]        wheel_new;
    logic [31:0]        wheel_d;
    logic [15:0]        xv, yv;
    logic signed [31:0] pos_base, pos_sum, pos_lo;

    assign o_in_stall = skid_full;
    assign in_accept  = i_in_valid && !skid_full;
    assign store_we   = in_accept && (t_op'(i_op) == OP_BYTE) && (r_byte_count < CNT_CRC_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert_x    <= 1'b0;
            r_invert_y    <= 1'b0;
            r_invert_whl  <= 1'b0;
            r_soft_lim_en <= 1'b0;
            r_lower_lim   <= 32'sh8000_0000;
            r_upper_lim   <= 32'sh7FFF_FFFF;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_INVERT_X:    r_invert_x    <= i_cfg_data[0];
                CFG_INVERT_Y:    r_invert_y    <= i_cfg_data[0];
                CFG_INVERT_WHL:  r_invert_whl  <= i_cfg_data[0];
                CFG_SOFT_LIM_EN: r_soft_lim_en <= i_cfg_data[0];
                CFG_LOWER_LIM:   r_lower_lim   <= $signed(i_cfg_data);
                CFG_UPPER_LIM:   r_upper_lim   <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // bytes 0..8; byte 9 is only needed in the transaction that carries it
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_byte_count] <= i_data_byte;
        end
    end

    always_comb begin
        n_byte_count  = r_byte_count;
        n_crc         = r_crc;
        n_wheel_last  = r_wheel_last;
        n_first_pkt   = r_first_pkt;
        n_wheel_accum = r_wheel_accum;
        n_focus_pos   = r_focus_pos;
        n_pos_synced  = r_pos_synced;
        n_legacy_cnt  = r_legacy_cnt;
        n_ok_cnt      = r_ok_cnt;
        n_fail_cnt    = r_fail_cnt;
        res           = '0;
        res_valid     = 1'b0;
        crc_calc      = (r_crc == CRC_ZERO) ? CRC_ONE : r_crc;
        pkt_pass      = 1'b0;
        wheel_new     = {r_store[0], r_store[1], r_store[2], r_store[3]};
        wheel_d       = r_invert_whl ? (r_wheel_last - wheel_new) : (wheel_new - r_wheel_last);
        xv            = {r_store[4], r_store[5]};
        yv            = {r_store[6], r_store[7]};
        pos_base      = r_pos_synced ? r_focus_pos : i_motor_position;
        pos_sum       = pos_base + $signed(r_wheel_accum);
        pos_lo        = pos_sum;

        if (r_invert_x) xv = 16'd0 - xv;
        if (r_invert_y) yv = 16'd0 - yv;

        if (r_soft_lim_en) begin
            if (pos_sum < r_lower_lim) pos_lo = r_lower_lim;
            if (r_upper_lim < pos_lo)  pos_lo = r_upper_lim;
        end

        if (in_accept) begin
            if (t_op'(i_op) == OP_FOCUS) begin
                if (!i_homing_busy) begin
                    n_wheel_accum = '0;
                    if (r_wheel_accum != '0) begin
                        n_focus_pos      = pos_lo;
                        n_pos_synced     = 1'b1;
                        res.kind         = KIND_MOVE;
                        res.focus_target = pos_lo;
                        res_valid        = 1'b1;
                    end
                end
            end else begin
                if (r_byte_count < CNT_CRC_LEN) n_crc = crc8_update(r_crc, i_data_byte);
                if (r_byte_count != CNT_MAX)    n_byte_count = r_byte_count + 4'd1;
                if (i_last_byte) begin
                    n_byte_count = '0;
                    n_crc        = '0;
                    // ten bytes: this transaction carries byte 9
                    if (r_byte_count == CNT_LAST) begin
                        res_valid = 1'b1;
                        res.kind  = KIND_VERDICT;
                        if (i_data_byte == CRC_ZERO) begin
                            n_legacy_cnt = r_legacy_cnt + 32'd1;
                            res.status   = ST_LEGACY;
                            pkt_pass     = 1'b1;
                        end else if (crc_calc != i_data_byte) begin
                            n_fail_cnt = r_fail_cnt + 32'd1;
                            res.status = ST_CRC_FAIL;
                        end else begin
                            n_ok_cnt   = r_ok_cnt + 32'd1;
                            res.status = ST_CRC_OK;
                            pkt_pass   = 1'b1;
                        end
                        if (pkt_pass) begin
                            if (r_first_pkt) begin
                                n_first_pkt = 1'b0;
                            end else begin
                                n_wheel_accum = r_wheel_accum + wheel_d;
                            end
                            n_wheel_last = wheel_new;
                            res.x_delta  = $signed(xv);
                            res.y_delta  = $signed(yv);
                            res.button   = |r_store[8];
                        end
                    end
                end
            end
        end

        res.legacy_total = n_legacy_cnt;
        res.ok_total     = n_ok_cnt;
        res.fail_total   = n_fail_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count  <= '0;
            r_crc         <= '0;
            r_wheel_last  <= '0;
            r_first_pkt   <= 1'b1;
            r_wheel_accum <= '0;
            r_focus_pos   <= '0;
            r_pos_synced  <= 1'b0;
            r_legacy_cnt  <= '0;
            r_ok_cnt      <= '0;
            r_fail_cnt    <= '0;
        end else begin
            r_byte_count  <= n_byte_count;
            r_crc         <= n_crc;
            r_wheel_last  <= n_wheel_last;
            r_first_pkt   <= n_first_pkt;
            r_wheel_accum <= n_wheel_accum;
            r_focus_pos   <= n_focus_pos;
            r_pos_synced  <= n_pos_synced;
            r_legacy_cnt  <= n_legacy_cnt;
            r_ok_cnt      <= n_ok_cnt;
            r_fail_cnt    <= n_fail_cnt;
        end
    end

    hpft_out_skid u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (res_valid),
        .i_result (res),
        .o_full   (skid_full),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_res)
    );

    assign o_kind         = out_res.kind;
    assign o_status       = out_res.status;
    assign o_x_delta      = out_res.x_delta;
    assign o_y_delta      = out_res.y_delta;
    assign o_button       = out_res.button;
    assign o_focus_target = out_res.focus_target;
    assign o_legacy_total = out_res.legacy_total;
    assign o_ok_total     = out_res.ok_total;
    assign o_fail_total   = out_res.fail_total;

`ifndef SYNTHESIS
    // a held skid entry means the output register is held too
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("skid entry held with empty output register");

    // any last byte restarts the packet framing
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_op && i_last_byte) |=> (r_byte_count == '0 && r_crc == '0))
        else $error("byte count or crc not restarted after last byte");

    // with sane limits a move target stays inside them
    a_target_in_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_MOVE && r_soft_lim_en && !(r_lower_lim > r_upper_lim))
        |-> (o_focus_target >= r_lower_lim && o_focus_target <= r_upper_lim))
        else $error("focus target outside soft limits");

    // the three packet counters advance by at most one between them per cycle
    a_one_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 ((r_legacy_cnt != $past(r_legacy_cnt)) + (r_ok_cnt != $past(r_ok_cnt))
             + (r_fail_cnt != $past(r_fail_cnt)) <= 1))
        else $error("more than one packet counter advanced");
`endif

endmodule

>>> verif/tb_handbox_packet_focus_tracker_core.sv
// Self-checking testbench for the handbox packet checker and focus target tracker.
module tb_handbox_packet_focus_tracker_core;
    timeunit 1ns;
    timeprecision 1ps;

    import hpft_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 90;
    localparam int PRINT_MAX   = 40;

    typedef struct {
        logic        op;
        logic [7:0]  data;
        logic        last;
        logic        homing;
        logic [31:0] motor;
    } t_hand_item;

    typedef enum int { PK_LEGACY, PK_GOOD, PK_BAD } t_pkt_form;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_op = 1'b0;
    logic [7:0]         i_data_byte = '0;
    logic               i_last_byte = 1'b0;
    logic               i_homing_busy = 1'b0;
    logic signed [31:0] i_motor_position = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_kind;
    t_status            o_status;
    logic signed [15:0] o_x_delta;
    logic signed [15:0] o_y_delta;
    logic               o_button;
    logic signed [31:0] o_focus_target;
    logic [31:0]        o_legacy_total;
    logic [31:0]        o_ok_total;
    logic [31:0]        o_fail_total;

    handbox_packet_focus_tracker_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .i_homing_busy    (i_homing_busy),
        .i_motor_position (i_motor_position),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kind           (o_kind),
        .o_status         (o_status),
        .o_x_delta        (o_x_delta),
        .o_y_delta        (o_y_delta),
        .o_button         (o_button),
        .o_focus_target   (o_focus_target),
        .o_legacy_total   (o_legacy_total),
        .o_ok_total       (o_ok_total),
        .o_fail_total     (o_fail_total)
    );

    // tracker state as the block should hold it
    logic [7:0]  pkt_bytes [PKT_LEN];
    logic [3:0]  byte_fill;
    logic [7:0]  crc_acc;
    logic [31:0] wheel_prev;
    bit          wheel_fresh;
    logic [31:0] wheel_sum;
    logic [31:0] foc_pos;
    bit          foc_synced;
    logic [31:0] legacy_seen, ok_seen, fail_seen;

    // configuration mirror
    bit          neg_x, neg_y, neg_wheel, lim_en;
    logic [31:0] lim_lo, lim_hi;

    t_hand_item  feed_q [$];
    t_result     outcome_q [$];
    int          fed_total, taken_total, errors, results_seen;
    bit          rst_done, in_taken;
    bit          quiet_in, quiet_out, hold_req, hold_done;
    int          in_gap, out_gap, hold_left;
    logic [31:0] gen_wheel;
    t_result     pred, want;
    bit          fired;
    t_hand_item  cur;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = acc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[7] ^ b[k];
            c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : CRC_ZERO);
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                   input logic [31:0] got_v);
        errors++;
        if (errors <= PRINT_MAX)
            $display("MISMATCH %s: expected %h got %h at result %0d",
                     what, want_v, got_v, results_seen);
    endtask

    task automatic track_transaction(input logic op, input logic [7:0] b, input logic last,
                                     input logic homing, input logic [31:0] motor,
                                     output bit got, output t_result r);
        logic [31:0] wheel_now, step;
        logic [7:0]  sum;
        logic [15:0] xv, yv;
        got = 1'b0;
        r = '0;
        if (op == OP_FOCUS) begin
            if (homing || wheel_sum == 32'd0)
                return;
            if (!foc_synced) begin
                foc_pos = motor;
                foc_synced = 1'b1;
            end
            foc_pos = foc_pos + wheel_sum;
            wheel_sum = 32'd0;
            if (lim_en) begin
                if ($signed(foc_pos) < $signed(lim_lo))
                    foc_pos = lim_lo;
                if ($signed(lim_hi) < $signed(foc_pos))
                    foc_pos = lim_hi;
            end
            got = 1'b1;
            r.kind = KIND_MOVE;
            r.focus_target = foc_pos;
            r.legacy_total = legacy_seen;
            r.ok_total = ok_seen;
            r.fail_total = fail_seen;
            return;
        end

        if (byte_fill < 4'(PKT_LEN))
            pkt_bytes[byte_fill] = b;
        if (byte_fill < 4'(CRC_LEN))
            crc_acc = crc8_step(crc_acc, b);
        if (byte_fill != CNT_MAX)
            byte_fill++;
        if (!last)
            return;
        sum = crc_acc;
        crc_acc = CRC_ZERO;
        if (byte_fill != 4'(PKT_LEN)) begin
            byte_fill = '0;
            return;
        end
        byte_fill = '0;

        got = 1'b1;
        r.kind = KIND_VERDICT;
        if (pkt_bytes[9] == CRC_ZERO) begin
            legacy_seen++;
            r.status = ST_LEGACY;
        end else begin
            if (sum == CRC_ZERO)
                sum = CRC_ONE;
            if (sum != pkt_bytes[9]) begin
                fail_seen++;
                r.status = ST_CRC_FAIL;
                r.legacy_total = legacy_seen;
                r.ok_total = ok_seen;
                r.fail_total = fail_seen;
                return;
            end
            ok_seen++;
            r.status = ST_CRC_OK;
        end

        wheel_now = {pkt_bytes[0], pkt_bytes[1], pkt_bytes[2], pkt_bytes[3]};
        if (wheel_fresh) begin
            wheel_fresh = 1'b0;
        end else begin
            step = wheel_now - wheel_prev;
            if (neg_wheel)
                step = -step;
            wheel_sum = wheel_sum + step;
        end
        wheel_prev = wheel_now;

        xv = {pkt_bytes[4], pkt_bytes[5]};
        yv = {pkt_bytes[6], pkt_bytes[7]};
        if (neg_x)
            xv = -xv;
        if (neg_y)
            yv = -yv;
        r.x_delta = xv;
        r.y_delta = yv;
        r.button = (pkt_bytes[8] != 8'h00);
        r.legacy_total = legacy_seen;
        r.ok_total = ok_seen;
        r.fail_total = fail_seen;
    endtask

    // ---------------- stimulus builders ----------------
    task automatic queue_byte(input logic [7:0] b, input logic last);
        t_hand_item it;
        it.op = OP_BYTE;
        it.data = b;
        it.last = last;
        it.homing = 1'($urandom_range(0, 1));
        it.motor = $urandom;
        feed_q.push_back(it);
        fed_total++;
    endtask

    task automatic queue_focus(input logic homing, input logic [31:0] motor);
        t_hand_item it;
        it.op = OP_FOCUS;
        it.data = 8'($urandom);
        it.last = 1'($urandom_range(0, 1));
        it.homing = homing;
        it.motor = motor;
        feed_q.push_back(it);
        fed_total++;
    endtask

    task automatic queue_packet(input t_pkt_form form, input logic [31:0] wheel,
                                input logic [15:0] xv, input logic [15:0] yv,
                                input logic [7:0] btn);
        logic [7:0] raw [PKT_LEN];
        logic [7:0] sum;
        raw[0] = wheel[31:24];
        raw[1] = wheel[23:16];
        raw[2] = wheel[15:8];
        raw[3] = wheel[7:0];
        raw[4] = xv[15:8];
        raw[5] = xv[7:0];
        raw[6] = yv[15:8];
        raw[7] = yv[7:0];
        raw[8] = btn;
        sum = CRC_ZERO;
        for (int k = 0; k < CRC_LEN; k++)
            sum = crc8_step(sum, raw[k]);
        if (sum == CRC_ZERO)
            sum = CRC_ONE;
        case (form)
            PK_LEGACY: raw[9] = CRC_ZERO;
            PK_GOOD:   raw[9] = sum;
            default: begin
                do raw[9] = 8'($urandom_range(1, 255)); while (raw[9] == sum);
            end
        endcase
        for (int k = 0; k < PKT_LEN; k++)
            queue_byte(raw[k], k == PKT_LEN - 1);
    endtask

    task automatic queue_random(input int n);
        int        made, pick, len;
        t_pkt_form form;
        made = 0;
        while (made < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                len = $urandom_range(0, 99);
                form = (len < 30) ? PK_LEGACY : (len < 75) ? PK_GOOD : PK_BAD;
                if ($urandom_range(0, 9) == 0)
                    gen_wheel = $urandom;
                else
                    gen_wheel = gen_wheel + $urandom_range(0, 600) - 300;
                queue_packet(form, gen_wheel, 16'($urandom), 16'($urandom),
                             ($urandom_range(0, 1) != 0) ? 8'($urandom) : 8'h00);
                made += PKT_LEN;
            end else if (pick < 82) begin
                queue_focus($urandom_range(0, 4) == 0, $urandom);
                made++;
            end else if (pick < 92) begin
                // packet of the wrong length, sometimes long enough to saturate the count
                do len = $urandom_range(1, 20); while (len == PKT_LEN);
                for (int k = 0; k < len; k++)
                    queue_byte(8'($urandom), k == len - 1);
                made += len;
            end else begin
                // stray byte: breaks the length of the following packet
                queue_byte(8'($urandom), 1'b0);
                made++;
            end
        end
    endtask

    task automatic set_reg(input t_cfg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_INVERT_X:    neg_x = val[0];
            CFG_INVERT_Y:    neg_y = val[0];
            CFG_INVERT_WHL:  neg_wheel = val[0];
            CFG_SOFT_LIM_EN: lim_en = val[0];
            CFG_LOWER_LIM:   lim_lo = val;
            CFG_UPPER_LIM:   lim_hi = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // block is idle once every item is taken and every result has come back
    task automatic drain;
        while (taken_total != fed_total) @(negedge i_clk);
        while (outcome_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // ---------------- input driver ----------------
    always @(negedge i_clk) begin
        if (rst_done && (!i_in_valid || in_taken)) begin
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (!quiet_in && $urandom_range(0, 9) == 0) begin
                in_gap = $urandom_range(1, 14) - 1;
                i_in_valid <= 1'b0;
            end else if (feed_q.size() > 0) begin
                cur = feed_q.pop_front();
                i_op <= cur.op;
                i_data_byte <= cur.data;
                i_last_byte <= cur.last;
                i_homing_busy <= cur.homing;
                i_motor_position <= cur.motor;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ---------------- output stall driver ----------------
    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_stall <= 1'b1;
        end else if (rst_done && !quiet_out && $urandom_range(0, 7) == 0) begin
            out_gap = $urandom_range(1, 14) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ---------------- prediction and result check ----------------
    always @(posedge i_clk) begin
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (in_taken) begin
            taken_total++;
            track_transaction(i_op, i_data_byte, i_last_byte, i_homing_busy,
                              i_motor_position, fired, pred);
            if (fired)
                outcome_q.push_back(pred);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (outcome_q.size() == 0) begin
                report_mismatch("result with none expected", 32'd0, 32'd1);
            end else begin
                want = outcome_q.pop_front();
                if (want.kind != o_kind)
                    report_mismatch("kind", 32'(want.kind), 32'(o_kind));
                if (want.status != o_status)
                    report_mismatch("status", 32'(want.status), 32'(o_status));
                if (want.x_delta != o_x_delta)
                    report_mismatch("x_delta", 32'(want.x_delta), 32'(o_x_delta));
                if (want.y_delta != o_y_delta)
                    report_mismatch("y_delta", 32'(want.y_delta), 32'(o_y_delta));
                if (want.button != o_button)
                    report_mismatch("button", 32'(want.button), 32'(o_button));
                if (want.focus_target != o_focus_target)
                    report_mismatch("focus_target", want.focus_target, o_focus_target);
                if (want.legacy_total != o_legacy_total)
                    report_mismatch("legacy_total", want.legacy_total, o_legacy_total);
                if (want.ok_total != o_ok_total)
                    report_mismatch("ok_total", want.ok_total, o_ok_total);
                if (want.fail_total != o_fail_total)
                    report_mismatch("fail_total", want.fail_total, o_fail_total);
            end
        end
    end

    // ---------------- watchdog ----------------
    initial begin
        int still;
        still = 0;
        while (still < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                still = 0;
            else
                still++;
        end
        $display("handbox_packet_focus_tracker_core verification failed");
        $finish;
    end

    // ---------------- test sequence ----------------
    initial begin
        byte_fill = '0;
        crc_acc = CRC_ZERO;
        wheel_prev = '0;
        wheel_fresh = 1'b1;
        wheel_sum = '0;
        foc_pos = '0;
        foc_synced = 1'b0;
        legacy_seen = '0;
        ok_seen = '0;
        fail_seen = '0;
        neg_x = 1'b0;
        neg_y = 1'b0;
        neg_wheel = 1'b0;
        lim_en = 1'b0;
        lim_lo = 32'h8000_0000;
        lim_hi = 32'h7FFF_FFFF;
        gen_wheel = '0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;

        // directed: all-zero body whose CRC maps to one, then all-ones wheel and button with extreme x and y
        queue_packet(PK_GOOD, 32'h0000_0000, 16'h0000, 16'h0000, 8'h00);
        queue_packet(PK_GOOD, 32'hFFFF_FFFF, 16'h8000, 16'h7FFF, 8'hFF);
        queue_focus(1'b1, 32'h8000_0000);   // homing: accumulator kept
        queue_focus(1'b0, 32'h7FFF_FFFF);   // first sync from the motor position
        queue_focus(1'b0, 32'h1234_5678);   // nothing accumulated
        queue_byte(8'hA5, 1'b0);            // two-byte packet, ignored
        queue_byte(8'h5A, 1'b1);
        drain();

        set_reg(CFG_INVERT_X, 32'd1);
        set_reg(CFG_INVERT_Y, 32'd1);
        set_reg(CFG_INVERT_WHL, 32'd1);
        set_reg(CFG_SOFT_LIM_EN, 32'd0);
        set_reg(CFG_LOWER_LIM, 32'h8000_0000);
        set_reg(CFG_UPPER_LIM, 32'h7FFF_FFFF);
        queue_random(150);
        drain();

        set_reg(CFG_INVERT_WHL, 32'd0);
        set_reg(CFG_SOFT_LIM_EN, 32'd1);
        set_reg(CFG_LOWER_LIM, foc_pos - 32'($urandom_range(0, 1500)));
        set_reg(CFG_UPPER_LIM, foc_pos + 32'($urandom_range(0, 1500)));
        queue_random(150);
        drain();

        // crossed limits, plus a long output hold with the sender kept busy
        set_reg(CFG_INVERT_X, 32'd0);
        set_reg(CFG_LOWER_LIM, foc_pos + 32'd500);
        set_reg(CFG_UPPER_LIM, foc_pos - 32'd500);
        quiet_in = 1'b1;
        hold_req = 1'b1;
        queue_random(150);
        drain();
        quiet_in = 1'b0;

        set_reg(CFG_INVERT_X, 32'd1);
        set_reg(CFG_INVERT_Y, 32'd0);
        set_reg(CFG_LOWER_LIM, 32'h8000_0000);
        set_reg(CFG_UPPER_LIM, 32'h7FFF_FFFF);
        queue_random(150);
        drain();

        set_reg(CFG_INVERT_WHL, 32'd1);
        set_reg(CFG_LOWER_LIM, foc_pos);
        set_reg(CFG_UPPER_LIM, foc_pos);
        queue_random(150);
        drain();

        // final stretch with no idling on either side
        set_reg(CFG_SOFT_LIM_EN, 32'd0);
        set_reg(CFG_INVERT_X, 32'd0);
        set_reg(CFG_INVERT_Y, 32'd0);
        set_reg(CFG_INVERT_WHL, 32'd0);
        quiet_in = 1'b1;
        quiet_out = 1'b1;
        queue_random(150);
        drain();
        repeat (12) @(negedge i_clk);

        if (errors == 0)
            $display("handbox_packet_focus_tracker_core verification clean");
        else
            $display("handbox_packet_focus_tracker_core verification failed");
        $finish;
    end

endmodule
